// ----- design/char_lcd_4bit_bus_sequencer_defines.svh -----
// Assertion macros used by the sequencer core, clcd_core
`ifndef CHAR_LCD_4BIT_BUS_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_4BIT_BUS_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define CLCD_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("clcd assertion failed");
// condition must never be seen at a clock edge out of reset
`define CLCD_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("clcd forbidden condition seen");
`else
`define CLCD_ASSERT(label, clk, rst_n, prop)
`define CLCD_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ----- design/clcd_pkg.sv -----
package clcd_pkg;

	// request codes
	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_INIT   = 2'd2,
		OP_DEINIT = 2'd3
	} opcode_t;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOT_INIT = 2'd1;
	localparam logic [1:0] ST_BUSY     = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_POWER_ON   = 3'd0;
	localparam logic [2:0] REG_INIT_WAIT1 = 3'd1;
	localparam logic [2:0] REG_INIT_WAIT2 = 3'd2;
	localparam logic [2:0] REG_INIT_WAIT3 = 3'd3;
	localparam logic [2:0] REG_PULSE      = 3'd4;
	localparam logic [2:0] REG_WR_CYCLE   = 3'd5;

	localparam int CFG_DATA_W = 20;
	localparam int WAIT_W     = 20;

	// sequence phases
	localparam logic [4:0] PH_IDLE      = 5'd0;
	localparam logic [4:0] PH_POWER     = 5'd1;
	localparam logic [4:0] PH_I1_PULSE  = 5'd2;
	localparam logic [4:0] PH_I1_LOW    = 5'd3;
	localparam logic [4:0] PH_I1_WAIT   = 5'd4;
	localparam logic [4:0] PH_I2_PULSE  = 5'd5;
	localparam logic [4:0] PH_I2_LOW    = 5'd6;
	localparam logic [4:0] PH_I2_WAIT   = 5'd7;
	localparam logic [4:0] PH_I3_PULSE  = 5'd8;
	localparam logic [4:0] PH_I3_LOW    = 5'd9;
	localparam logic [4:0] PH_I3_WAIT   = 5'd10;
	localparam logic [4:0] PH_I4_PULSE  = 5'd11;
	localparam logic [4:0] PH_INIT_LAST = 5'd12;
	localparam logic [4:0] PH_W_HI      = 5'd13;
	localparam logic [4:0] PH_W_HI_LOW  = 5'd14;
	localparam logic [4:0] PH_W_LO      = 5'd15;
	localparam logic [4:0] PH_W_LO_LOW  = 5'd16;
	localparam logic [4:0] PH_W_LAST    = 5'd17;

	// init nibbles
	localparam logic [3:0] NIB_INIT_8BIT = 4'h3;
	localparam logic [3:0] NIB_INIT_4BIT = 4'h2;
	localparam logic [3:0] NIB_ZERO      = 4'h0;

	typedef struct packed {
		logic [1:0] opcode;
		logic       is_data;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic       rs_level;
		logic       enable_level;
		logic [3:0] bus_nibble;
		logic       busy_res;
		logic       is_initialized;
		logic [1:0] status;
		logic       done_res;
	} out_item_t;

	typedef struct packed {
		logic [19:0] power_on_ticks;
		logic [15:0] init_wait1_ticks;
		logic [15:0] init_wait2_ticks;
		logic [15:0] init_wait3_ticks;
		logic [7:0]  pulse_ticks;
		logic [15:0] write_cycle_ticks;
	} cfg_t;

endpackage

// ----- design/char_lcd_4bit_bus_sequencer.sv -----
// Channel   Direction  Payload      Handshake
// in        input      in_item_t    in_valid / in_stall
// out       output     out_item_t   out_valid / out_stall
// cfg       input      cfg_data     cfg_we / cfg_index (write only)
//
// An item is registered on acceptance, and its result is registered once the
// result register is free. Throughput: one item per cycle while the result is
// not stalled; the state update is a single pass of the phase/count logic in
// clcd_core between the input and result registers.
// Reset clears the state and both valid flags and loads the timing defaults.
// A stalled result holds the item behind it; in_stall rises only then.
module char_lcd_4bit_bus_sequencer
	import clcd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_item_q;
	out_item_t result;
	cfg_t      cfg;
	logic      step_en;
	logic      in_take;
	logic      out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign step_en  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	clcd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	clcd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take)
			item_s1 <= in_item;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en)
			out_item_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ----- design/clcd_cfg.sv -----
module clcd_cfg
	import clcd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// timing registers, reset to the power-up defaults
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_on_ticks    <= 20'd50000;
			cfg_q.init_wait1_ticks  <= 16'd4500;
			cfg_q.init_wait2_ticks  <= 16'd150;
			cfg_q.init_wait3_ticks  <= 16'd150;
			cfg_q.pulse_ticks       <= 8'd1;
			cfg_q.write_cycle_ticks <= 16'd50;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POWER_ON:   cfg_q.power_on_ticks    <= cfg_data[19:0];
				REG_INIT_WAIT1: cfg_q.init_wait1_ticks  <= cfg_data[15:0];
				REG_INIT_WAIT2: cfg_q.init_wait2_ticks  <= cfg_data[15:0];
				REG_INIT_WAIT3: cfg_q.init_wait3_ticks  <= cfg_data[15:0];
				REG_PULSE:      cfg_q.pulse_ticks       <= cfg_data[7:0];
				REG_WR_CYCLE:   cfg_q.write_cycle_ticks <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/clcd_core.sv -----
`include "char_lcd_4bit_bus_sequencer_defines.svh"

module clcd_core
	import clcd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step_en,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t result
);

	logic [4:0]        phase_q;
	logic [WAIT_W-1:0] wait_q;
	logic [7:0]        held_q;
	logic              rs_q;
	logic              en_q;
	logic [3:0]        nib_q;
	logic              init_q;

	logic [4:0]        phase_d;
	logic [WAIT_W-1:0] wait_d;
	logic [7:0]        held_d;
	logic              rs_d;
	logic              en_d;
	logic [3:0]        nib_d;
	logic              init_d;
	logic [1:0]        status_d;
	logic              done_d;
	logic              do_enter;
	logic [4:0]        target;

	// one tick: pick the phase to enter (if any), then apply its entry actions
	always_comb begin
		phase_d  = phase_q;
		wait_d   = wait_q;
		held_d   = held_q;
		rs_d     = rs_q;
		en_d     = en_q;
		nib_d    = nib_q;
		init_d   = init_q;
		status_d = ST_OK;
		done_d   = 1'b0;
		do_enter = 1'b0;
		target   = PH_IDLE;

		if (phase_q != PH_IDLE) begin
			if (item.opcode != OP_TICK)
				status_d = ST_BUSY;
			if (wait_q != '0) begin
				wait_d = wait_q - 1'b1;
			end else if (phase_q == PH_INIT_LAST) begin
				phase_d = PH_IDLE;
				init_d  = 1'b1;
				done_d  = 1'b1;
			end else if (phase_q >= PH_W_LAST) begin
				phase_d = PH_IDLE;
				done_d  = 1'b1;
			end else begin
				do_enter = 1'b1;
				target   = phase_q + 5'd1;
			end
		end else begin
			case (item.opcode)
				OP_WRITE: begin
					if (!init_q) begin
						status_d = ST_NOT_INIT;
					end else begin
						rs_d     = item.is_data;
						held_d   = item.data_byte;
						do_enter = 1'b1;
						target   = PH_W_HI;
					end
				end
				OP_INIT: begin
					if (!init_q) begin
						do_enter = 1'b1;
						target   = PH_POWER;
					end
				end
				OP_DEINIT: begin
					if (init_q) begin
						rs_d   = 1'b0;
						en_d   = 1'b0;
						nib_d  = NIB_ZERO;
						init_d = 1'b0;
					end
				end
				default: ;
			endcase
		end

		// phase entry actions
		if (do_enter) begin
			phase_d = target;
			wait_d  = '0;
			unique case (target) inside
				PH_POWER: begin
					rs_d   = 1'b0;
					en_d   = 1'b0;
					nib_d  = NIB_ZERO;
					wait_d = cfg.power_on_ticks;
				end
				PH_I1_PULSE, PH_I2_PULSE, PH_I3_PULSE: begin
					rs_d   = 1'b0;
					nib_d  = NIB_INIT_8BIT;
					en_d   = 1'b1;
					wait_d = WAIT_W'(cfg.pulse_ticks);
				end
				PH_I4_PULSE: begin
					rs_d   = 1'b0;
					nib_d  = NIB_INIT_4BIT;
					en_d   = 1'b1;
					wait_d = WAIT_W'(cfg.pulse_ticks);
				end
				PH_I1_LOW, PH_I2_LOW, PH_I3_LOW, PH_INIT_LAST,
				PH_W_HI_LOW, PH_W_LO_LOW: begin
					en_d   = 1'b0;
					wait_d = WAIT_W'(cfg.pulse_ticks);
				end
				PH_I1_WAIT: wait_d = WAIT_W'(cfg.init_wait1_ticks);
				PH_I2_WAIT: wait_d = WAIT_W'(cfg.init_wait2_ticks);
				PH_I3_WAIT: wait_d = WAIT_W'(cfg.init_wait3_ticks);
				PH_W_HI: begin
					nib_d  = held_d[7:4];
					en_d   = 1'b1;
					wait_d = WAIT_W'(cfg.pulse_ticks);
				end
				PH_W_LO: begin
					nib_d  = held_d[3:0];
					en_d   = 1'b1;
					wait_d = WAIT_W'(cfg.pulse_ticks);
				end
				PH_W_LAST: wait_d = WAIT_W'(cfg.write_cycle_ticks);
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			wait_q  <= '0;
			held_q  <= '0;
			rs_q    <= 1'b0;
			en_q    <= 1'b0;
			nib_q   <= NIB_ZERO;
			init_q  <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			wait_q  <= wait_d;
			held_q  <= held_d;
			rs_q    <= rs_d;
			en_q    <= en_d;
			nib_q   <= nib_d;
			init_q  <= init_d;
		end
	end

	// pin and status view after this tick's update
	assign result.rs_level       = rs_d;
	assign result.enable_level   = en_d;
	assign result.bus_nibble     = nib_d;
	assign result.busy_res       = (phase_d != PH_IDLE);
	assign result.is_initialized = init_d;
	assign result.status         = status_d;
	assign result.done_res       = done_d;

	`CLCD_ASSERT(a_done_goes_idle, clk, arst_n, (step_en && done_d) |=> (phase_q == PH_IDLE))
	`CLCD_ASSERT(a_init_only_by_seq, clk, arst_n, $rose(init_q) |-> $past(phase_q == PH_INIT_LAST))
	`CLCD_NEVER(a_enable_when_idle, clk, arst_n, en_q && (phase_q == PH_IDLE))
	`CLCD_NEVER(a_idle_count_clear, clk, arst_n, (phase_q == PH_IDLE) && (wait_q != '0))

endmodule

// ----- verif/clcd_pin_checker.sv -----
`timescale 1ns / 1ps

// Watches the item, result and register write channels of the LCD bus
// sequencer. It predicts the pin levels and status of every accepted item
// and compares them with the results in order.
module clcd_pin_checker
	import clcd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  in_item_t              in_item,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	// predicted timing registers and sequencer state
	cfg_t              timing;
	logic [4:0]        seq_phase;
	logic [WAIT_W-1:0] tick_left;
	logic [7:0]        byte_hold;
	logic              rs_q;
	logic              en_q;
	logic [3:0]        nib_q;
	logic              ready_q;

	// expected pin states, oldest first
	out_item_t pin_states_q[$];

	function automatic void clear_pins();
		rs_q = 1'b0;
		en_q = 1'b0;
		nib_q = NIB_ZERO;
	endfunction

	// entry actions of a phase and its delay
	function automatic void enter_step(logic [4:0] p);
		seq_phase = p;
		tick_left = '0;
		case (p)
			PH_POWER: begin
				clear_pins();
				tick_left = timing.power_on_ticks;
			end
			PH_I1_PULSE, PH_I2_PULSE, PH_I3_PULSE: begin
				rs_q = 1'b0;
				nib_q = NIB_INIT_8BIT;
				en_q = 1'b1;
				tick_left = WAIT_W'(timing.pulse_ticks);
			end
			PH_I4_PULSE: begin
				rs_q = 1'b0;
				nib_q = NIB_INIT_4BIT;
				en_q = 1'b1;
				tick_left = WAIT_W'(timing.pulse_ticks);
			end
			PH_I1_LOW, PH_I2_LOW, PH_I3_LOW, PH_INIT_LAST, PH_W_HI_LOW, PH_W_LO_LOW: begin
				en_q = 1'b0;
				tick_left = WAIT_W'(timing.pulse_ticks);
			end
			PH_I1_WAIT: tick_left = WAIT_W'(timing.init_wait1_ticks);
			PH_I2_WAIT: tick_left = WAIT_W'(timing.init_wait2_ticks);
			PH_I3_WAIT: tick_left = WAIT_W'(timing.init_wait3_ticks);
			PH_W_HI: begin
				nib_q = byte_hold[7:4];
				en_q = 1'b1;
				tick_left = WAIT_W'(timing.pulse_ticks);
			end
			PH_W_LO: begin
				nib_q = byte_hold[3:0];
				en_q = 1'b1;
				tick_left = WAIT_W'(timing.pulse_ticks);
			end
			PH_W_LAST: tick_left = WAIT_W'(timing.write_cycle_ticks);
			default: seq_phase = PH_IDLE;
		endcase
	endfunction

	// one tick of a running sequence; returns 1 when it finishes
	function automatic logic advance_step();
		if (tick_left != '0) begin
			tick_left = tick_left - 1'b1;
			return 1'b0;
		end
		if (seq_phase == PH_INIT_LAST) begin
			seq_phase = PH_IDLE;
			ready_q = 1'b1;
			return 1'b1;
		end
		if (seq_phase >= PH_W_LAST) begin
			seq_phase = PH_IDLE;
			return 1'b1;
		end
		enter_step(seq_phase + 5'd1);
		return 1'b0;
	endfunction

	// pin levels and status after one tick item
	function automatic out_item_t lcd_tick(in_item_t it);
		out_item_t  r;
		logic [1:0] st;
		logic       fin;
		st = ST_OK;
		fin = 1'b0;
		if (seq_phase != PH_IDLE) begin
			// requests are refused, the sequence still moves on
			if (it.opcode != OP_TICK) st = ST_BUSY;
			fin = advance_step();
		end else begin
			case (it.opcode)
				OP_WRITE: begin
					if (!ready_q) begin
						st = ST_NOT_INIT;
					end else begin
						rs_q = it.is_data;
						byte_hold = it.data_byte;
						enter_step(PH_W_HI);
					end
				end
				OP_INIT: begin
					if (!ready_q) enter_step(PH_POWER);
				end
				OP_DEINIT: begin
					// done within the tick, no done pulse
					if (ready_q) begin
						clear_pins();
						ready_q = 1'b0;
					end
				end
				default: ;
			endcase
		end
		r.rs_level = rs_q;
		r.enable_level = en_q;
		r.bus_nibble = nib_q;
		r.busy_res = (seq_phase != PH_IDLE);
		r.is_initialized = ready_q;
		r.status = st;
		r.done_res = fin;
		return r;
	endfunction

	function automatic int field_bad(string name, logic [3:0] want, logic [3:0] got);
		if (got === want) return 0;
		$error("%s: expected %0d, got %0d", name, want, got);
		return 1;
	endfunction

	function automatic int mismatches(out_item_t want, out_item_t got);
		int n;
		n = 0;
		n += field_bad("rs_level", 4'(want.rs_level), 4'(got.rs_level));
		n += field_bad("enable_level", 4'(want.enable_level), 4'(got.enable_level));
		n += field_bad("bus_nibble", want.bus_nibble, got.bus_nibble);
		n += field_bad("busy_res", 4'(want.busy_res), 4'(got.busy_res));
		n += field_bad("is_initialized", 4'(want.is_initialized), 4'(got.is_initialized));
		n += field_bad("status", 4'(want.status), 4'(got.status));
		n += field_bad("done_res", 4'(want.done_res), 4'(got.done_res));
		return n;
	endfunction

	// register writes, item prediction and result compare
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// power_on, wait1, wait2, wait3, pulse, write cycle
			timing = '{20'd50000, 16'd4500, 16'd150, 16'd150, 8'd1, 16'd50};
			seq_phase = PH_IDLE;
			tick_left = '0;
			byte_hold = 8'h00;
			clear_pins();
			ready_q = 1'b0;
			pin_states_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_POWER_ON:   timing.power_on_ticks = cfg_data[19:0];
					REG_INIT_WAIT1: timing.init_wait1_ticks = cfg_data[15:0];
					REG_INIT_WAIT2: timing.init_wait2_ticks = cfg_data[15:0];
					REG_INIT_WAIT3: timing.init_wait3_ticks = cfg_data[15:0];
					REG_PULSE:      timing.pulse_ticks = cfg_data[7:0];
					REG_WR_CYCLE:   timing.write_cycle_ticks = cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				pin_states_q.push_back(lcd_tick(in_item));
			end
			if (out_valid && !out_stall) begin
				if (pin_states_q.size() == 0) begin
					$error("result with no item waiting: %p", out_item);
					fail_count <= fail_count + 1;
				end else begin
					fail_count <= fail_count + mismatches(pin_states_q.pop_front(), out_item);
				end
			end
			pending <= pin_states_q.size();
		end
	end

endmodule

// ----- verif/tb_char_lcd_4bit_bus_sequencer.sv -----
`timescale 1ns / 1ps

module tb_char_lcd_4bit_bus_sequencer;
	import clcd_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_item;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_item;
	logic                  cfg_we;
	logic [2:0]            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int   fail_count;
	int   pending;
	logic last_busy = 1'b0;
	bit   calm = 1'b0;
	bit   hold_done = 1'b0;
	int   items_sent = 0;
	int   rand_sent = 0;
	int   settings_run = 1;

	char_lcd_4bit_bus_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	clcd_pin_checker pin_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#48_000_000;
		$display("Some tests failed");
		$finish;
	end

	// busy flag of the latest result, used to run sequences out
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) last_busy <= out_item.busy_res;
	end

	// result side: random stalls, one long hold-off in the random part
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && rand_sent >= 300) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (250) @(posedge clk);
			end
			out_stall <= !calm && ($urandom_range(99) < 36);
		end
	end

	function automatic in_item_t rand_item(opcode_t op);
		in_item_t it;
		it.opcode = op;
		it.is_data = 1'($urandom_range(1, 0));
		it.data_byte = 8'($urandom_range(255, 0));
		return it;
	endfunction

	function automatic in_item_t byte_item(logic rs, logic [7:0] b);
		in_item_t it;
		it.opcode = OP_WRITE;
		it.is_data = rs;
		it.data_byte = b;
		return it;
	endfunction

	// mostly ticks and writes so initialized traffic dominates
	function automatic opcode_t pick_op();
		int r;
		r = $urandom_range(99);
		if (r < 40) return OP_TICK;
		if (r < 72) return OP_WRITE;
		if (r < 90) return OP_INIT;
		return OP_DEINIT;
	endfunction

	function automatic cfg_t small_timing();
		cfg_t t;
		t.power_on_ticks = 20'($urandom_range(12, 0));
		t.init_wait1_ticks = 16'($urandom_range(6, 0));
		t.init_wait2_ticks = 16'($urandom_range(6, 0));
		t.init_wait3_ticks = 16'($urandom_range(6, 0));
		t.pulse_ticks = 8'($urandom_range(3, 1));
		t.write_cycle_ticks = 16'($urandom_range(8, 0));
		return t;
	endfunction

	// offer one item, sometimes after a random gap, and wait until it is taken
	task automatic send_item(in_item_t it);
		if (!calm && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic send_op(opcode_t op);
		send_item(rand_item(op));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// feed ticks until the last result shows the block idle
	task automatic settle_idle();
		drain();
		while (last_busy) begin
			while (last_busy) send_op(OP_TICK);
			drain();
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_timing(cfg_t t);
		write_reg(REG_POWER_ON, t.power_on_ticks);
		write_reg(REG_INIT_WAIT1, CFG_DATA_W'(t.init_wait1_ticks));
		write_reg(REG_INIT_WAIT2, CFG_DATA_W'(t.init_wait2_ticks));
		write_reg(REG_INIT_WAIT3, CFG_DATA_W'(t.init_wait3_ticks));
		write_reg(REG_PULSE, CFG_DATA_W'(t.pulse_ticks));
		write_reg(REG_WR_CYCLE, CFG_DATA_W'(t.write_cycle_ticks));
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	task automatic run_random(int n);
		repeat (n) begin
			calm = (rand_sent >= 500 && rand_sent < 650);
			send_op(pick_op());
			rand_sent++;
		end
		calm = 1'b0;
	endtask

	initial begin
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = REG_POWER_ON;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short init waits; pulse and write cycle keep their reset values
		write_reg(REG_POWER_ON, 20'd6);
		write_reg(REG_INIT_WAIT1, 20'd5);
		write_reg(REG_INIT_WAIT2, 20'd4);
		write_reg(REG_INIT_WAIT3, 20'd3);
		cfg_we <= 1'b0;
		settings_run++;

		// refusals before init, full init sequence, writes at reset timing
		send_op(OP_WRITE);
		send_op(OP_DEINIT);
		send_op(OP_TICK);
		send_op(OP_INIT);
		send_op(OP_WRITE);
		send_op(OP_INIT);
		send_op(OP_DEINIT);
		settle_idle();
		send_op(OP_INIT);
		send_item(byte_item(1'b0, 8'h00));
		send_op(OP_WRITE);
		settle_idle();
		send_item(byte_item(1'b1, 8'hFF));
		settle_idle();
		send_item(byte_item(1'b1, 8'hA5));
		settle_idle();
		send_op(OP_DEINIT);
		send_op(OP_WRITE);
		drain();

		// shortest timing everywhere but the pulse, which keeps its reset value
		load_timing('{20'd0, 16'd0, 16'd0, 16'd0, 8'd1, 16'd0});
		run_random(100);
		settle_idle();

		// several short random timings
		repeat (4) begin
			load_timing(small_timing());
			run_random(150);
			settle_idle();
		end

		// bring the bus up, then full-scale init registers and a stretched write
		send_op(OP_DEINIT);
		send_op(OP_INIT);
		settle_idle();
		load_timing('{20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd12, 16'd30});
		send_op(OP_INIT);
		send_op(OP_WRITE);
		send_op(OP_DEINIT);
		send_op(OP_WRITE);
		settle_idle();
		send_op(OP_DEINIT);
		drain();
		repeat (8) @(posedge clk);

		$display("Covered %0d items (%0d random) under %0d timing settings.",
			items_sent, rand_sent, settings_run);
		$display("Included reset pulse and write timing, full-scale registers, refused requests and a long result stall.");
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
